// ===== hdl/md4bc_pkg.sv =====
// Shared types, constants and step tables for the MD4 block compression core.
// No dependencies; every other file in hdl/ except md4bc_ram imports this package.
package md4bc_pkg;

	localparam int WORD_W      = 32;
	localparam int IDX_W       = 4;            // word position within a block
	localparam int STEP_W      = 6;            // 48 steps
	localparam int LAST_STEP   = 47;
	localparam int RAM_DEPTH   = 32;           // two banks of sixteen words
	localparam int RAM_ADDR_W  = 5;

	localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
	localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
	localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
	localparam logic [WORD_W-1:0] IV_D = 32'h10325476;
	localparam logic [WORD_W-1:0] K_R2 = 32'h5a827999;
	localparam logic [WORD_W-1:0] K_R3 = 32'h6ed9eba1;

	localparam logic [1:0] ROUND_F = 2'd0;
	localparam logic [1:0] ROUND_G = 2'd1;
	localparam logic [1:0] ROUND_H = 2'd2;

	// Block command handed from the front to the back.
	typedef struct packed {
		logic bank;
		logic restart;
		logic ends_run;
	} cmd_t;

	// Bank release from the back to the front.
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	// Message word index used by a step.
	function automatic logic [IDX_W-1:0] msg_index(input logic [STEP_W-1:0] step);
		logic [IDX_W-1:0] j;
		begin
			j = step[IDX_W-1:0];
			case (step[5:4])
				ROUND_F: msg_index = j;
				ROUND_G: msg_index = {j[1:0], j[3:2]};
				ROUND_H: msg_index = {j[0], j[1], j[2], j[3]};
				default: msg_index = j;
			endcase
		end
	endfunction

	// Left rotation amount of a step.
	function automatic logic [4:0] rot_amount(input logic [STEP_W-1:0] step);
		logic [4:0] r;
		begin
			r = 5'd3;
			case (step[5:4])
				ROUND_F: begin
					case (step[1:0])
						2'd0: r = 5'd3;
						2'd1: r = 5'd7;
						2'd2: r = 5'd11;
						default: r = 5'd19;
					endcase
				end
				ROUND_G: begin
					case (step[1:0])
						2'd0: r = 5'd3;
						2'd1: r = 5'd5;
						2'd2: r = 5'd9;
						default: r = 5'd13;
					endcase
				end
				default: begin
					case (step[1:0])
						2'd0: r = 5'd3;
						2'd1: r = 5'd9;
						2'd2: r = 5'd11;
						default: r = 5'd15;
					endcase
				end
			endcase
			rot_amount = r;
		end
	endfunction

	function automatic logic [WORD_W-1:0] round_const(input logic [STEP_W-1:0] step);
		case (step[5:4])
			ROUND_F: round_const = '0;
			ROUND_G: round_const = K_R2;
			default: round_const = K_R3;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] round_fn(input logic [STEP_W-1:0] step,
		input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
		input logic [WORD_W-1:0] z);
		case (step[5:4])
			ROUND_F: round_fn = (x & y) | (~x & z);
			ROUND_G: round_fn = (x & y) | (x & z) | (y & z);
			default: round_fn = x ^ y ^ z;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
		input logic [4:0] s);
		logic [2*WORD_W-1:0] t;
		begin
			t = {v, v} << s;
			rotl = t[2*WORD_W-1:WORD_W];
		end
	endfunction

endpackage

// ===== hdl/md4bc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module md4bc_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hdl/md4bc_front.sv =====
// Input side: takes message words, writes them into the free bank and issues
// a block command on the sixteenth word. Depends on md4bc_pkg.
module md4bc_front import md4bc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [WORD_W-1:0]     s_tdata,
	input  logic                  s_tuser,
	input  logic                  s_tlast,
	input  rel_t                  rel,
	output logic                  push,
	output cmd_t                  push_cmd,
	output logic                  wr_en,
	output logic [RAM_ADDR_W-1:0] wr_addr,
	output logic [WORD_W-1:0]     wr_data
);

	logic [IDX_W-1:0] idx_q;
	logic             bank_q;
	logic             blk_restart_q;
	logic [1:0]       busy_q;
	logic [1:0]       busy_nxt;
	logic             accept;
	logic [IDX_W-1:0] eff_idx;
	logic             eff_restart;

	// Hold off while the bank being filled is still owned by the back.
	assign s_tready    = !busy_q[bank_q];
	assign accept      = s_tvalid && s_tready;
	assign eff_idx     = s_tuser ? '0 : idx_q;
	assign eff_restart = s_tuser || blk_restart_q;

	assign wr_en   = accept;
	assign wr_addr = {bank_q, eff_idx};
	assign wr_data = s_tdata;

	assign push              = accept && (eff_idx == IDX_W'(15));
	assign push_cmd.bank     = bank_q;
	assign push_cmd.restart  = eff_restart;
	assign push_cmd.ends_run = s_tlast;

	// Free the released bank, claim the bank just filled.
	always_comb begin
		busy_nxt = busy_q;
		if (rel.valid) begin
			busy_nxt[rel.bank] = 1'b0;
		end
		if (push) begin
			busy_nxt[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			bank_q        <= 1'b0;
			blk_restart_q <= 1'b0;
			busy_q        <= '0;
		end else begin
			busy_q <= busy_nxt;
			if (accept) begin
				if (push) begin
					idx_q         <= '0;
					blk_restart_q <= 1'b0;
					bank_q        <= !bank_q;
				end else begin
					idx_q         <= eff_idx + IDX_W'(1);
					blk_restart_q <= eff_restart;
				end
			end
		end
	end

endmodule

// ===== hdl/md4bc_cmd_fifo.sv =====
// Two-entry queue of block commands between front and back.
// Depends on md4bc_pkg.
module md4bc_cmd_fifo import md4bc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign valid = (count_q != 2'd0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hdl/md4bc_back.sv =====
// Compression side: pops block commands, runs the 48 steps one per cycle,
// folds into the chaining value and, at the end of a run, emits it. Depends on md4bc_pkg.
module md4bc_back import md4bc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  pop,
	output rel_t                  rel,
	output logic [RAM_ADDR_W-1:0] rd_addr,
	input  logic [WORD_W-1:0]     rd_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [WORD_W-1:0]     m_tdata,
	output logic                  m_tlast
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_ADD  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic [STEP_W-1:0]   step_nxt;
	logic                bank_q;
	logic                ends_q;
	logic [1:0]          emit_idx_q;
	logic [WORD_W-1:0]   chain_q [4];
	logic [WORD_W-1:0]   wa_q, wb_q, wc_q, wd_q;
	logic [WORD_W-1:0]   step_sum;
	logic [WORD_W-1:0]   step_new;
	logic                last_step;

	assign step_nxt  = step_q + STEP_W'(1);
	assign last_step = (step_q == STEP_W'(LAST_STEP));
	assign pop       = (state_q == ST_IDLE) && cmd_valid;

	// Address runs one step ahead of the data for the registered read.
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = {cmd.bank, msg_index('0)};
		end else begin
			rd_addr = {bank_q, msg_index(step_nxt)};
		end
	end

	assign rel.valid = (state_q == ST_RUN) && last_step;
	assign rel.bank  = bank_q;

	assign step_sum = wa_q + round_fn(step_q, wb_q, wc_q, wd_q) + rd_data
		+ round_const(step_q);
	assign step_new = rotl(step_sum, rot_amount(step_q));

	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = chain_q[emit_idx_q];
	assign m_tlast  = (emit_idx_q == 2'd3);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bank_q <= cmd.bank;
				ends_q <= cmd.ends_run;
				if (cmd.restart) begin
					wa_q <= IV_A;
					wb_q <= IV_B;
					wc_q <= IV_C;
					wd_q <= IV_D;
				end else begin
					wa_q <= chain_q[0];
					wb_q <= chain_q[1];
					wc_q <= chain_q[2];
					wd_q <= chain_q[3];
				end
			end
			ST_RUN: begin
				// Rotate the working words so the updated one is always in slot B.
				wa_q <= wd_q;
				wb_q <= step_new;
				wc_q <= wb_q;
				wd_q <= wc_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			emit_idx_q <= '0;
			chain_q[0] <= IV_A;
			chain_q[1] <= IV_B;
			chain_q[2] <= IV_C;
			chain_q[3] <= IV_D;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						step_q  <= '0;
						state_q <= ST_RUN;
						if (cmd.restart) begin
							chain_q[0] <= IV_A;
							chain_q[1] <= IV_B;
							chain_q[2] <= IV_C;
							chain_q[3] <= IV_D;
						end
					end
				end
				ST_RUN: begin
					step_q <= step_nxt;
					if (last_step) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					chain_q[0] <= chain_q[0] + wa_q;
					chain_q[1] <= chain_q[1] + wb_q;
					chain_q[2] <= chain_q[2] + wc_q;
					chain_q[3] <= chain_q[3] + wd_q;
					emit_idx_q <= '0;
					state_q    <= ends_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (m_tready) begin
						emit_idx_q <= emit_idx_q + 2'd1;
						if (emit_idx_q == 2'd3) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_pop_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_RUN) && (step_q == '0))
		else $error("block start did not enter step 0");

	a_last_step_adds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && last_step |=> (state_q == ST_ADD))
		else $error("step 47 not followed by chaining add");

	a_release_once: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |=> !rel.valid)
		else $error("bank released on two cycles in a row");

	a_emit_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> (state_q == ST_IDLE))
		else $error("emission continued after the D word");
`endif

endmodule

// ===== hdl/md4_block_compression_top.sv =====
// Top level of the MD4 block compression core: front, command queue, back
// and the two-bank message RAM. Depends on md4bc_pkg and all md4bc_* modules.
//
//  channel | direction | tdata           | tuser       | tlast
//  --------+-----------+-----------------+-------------+------------------------
//  s_*     | in        | message_word    | restart     | ends_run
//  m_*     | out       | chain_word      | (none)      | last_word (on D)
//
// Flow: the front takes one word per cycle while its bank is free. The back
// handles a block as one read issue, 48 steps through the single step unit
// and one chaining add, plus four output words when the block ends a run.
// Reset: arst_n clears control, loads the initial chaining value; the RAM is
// not cleared, each word being written before it is read.
// Stalls: a held m_tready stalls only the back; the front keeps filling the
// other bank until both banks are owned by queued or running blocks.
module md4_block_compression_top import md4bc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // [31:0] message_word
	input  logic              s_tuser,   // [0] restart
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata,   // [31:0] chain_word
	output logic              m_tlast
);

	logic                  push;
	cmd_t                  push_cmd;
	logic                  pop;
	logic                  cmd_valid;
	cmd_t                  head;
	rel_t                  rel;
	logic                  wr_en;
	logic [RAM_ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0]     wr_data;
	logic [RAM_ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0]     rd_data;

	// Front: classify words, fill a bank, issue a block command on word 16.
	md4bc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.rel      (rel),
		.push     (push),
		.push_cmd (push_cmd),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// Queue: decouple the front from the compression rounds.
	md4bc_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.valid    (cmd_valid),
		.head     (head)
	);

	// Message store: bank bit in the top address bit.
	md4bc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Back: run the steps, add into the chaining value, emit on end of run.
	md4bc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (head),
		.pop       (pop),
		.rel       (rel),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== test/md4_chain_checker.sv =====
// Scoreboard for the MD4 block compression core: watches both stream channels,
// predicts the chaining words and compares them in order.
// Depends on md4bc_pkg for widths and the MD4 constants.
module md4_chain_checker
	import md4bc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // [31:0] message_word
	input  logic              s_tuser,   // [0] restart
	input  logic              s_tlast,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [WORD_W-1:0] m_tdata,   // [31:0] chain_word
	input  logic              m_tlast,
	output int                mismatches,
	output int                words_owed,
	output int                words_taken,
	output int                blocks_done,
	output int                digests_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [WORD_W-1:0] chain;
		logic              last;
	} chain_out_t;

	chain_out_t        chain_words_due [$];
	logic [WORD_W-1:0] chain_val [4];
	logic [WORD_W-1:0] msg_buf [16];
	logic [IDX_W-1:0]  fill_pos;

	// Run the 48 steps over msg_buf and fold the result into chain_val.
	task automatic fold_block();
		logic [WORD_W-1:0] w [4];
		logic [WORD_W-1:0] x, y, z, f, k, sum;
		int t, j, idx, s;
		for (int q = 0; q < 4; q++)
			w[q] = chain_val[q];
		for (int i = 0; i < 48; i++) begin
			t = (4 - (i % 4)) % 4;
			j = i % 16;
			x = w[(t + 1) % 4];
			y = w[(t + 2) % 4];
			z = w[(t + 3) % 4];
			case (i / 16)
				0: begin
					f = (x & y) | (~x & z);
					k = '0;
					idx = j;
					case (j % 4)
						0: s = 3;
						1: s = 7;
						2: s = 11;
						default: s = 19;
					endcase
				end
				1: begin
					f = (x & y) | (x & z) | (y & z);
					k = K_R2;
					idx = (j % 4) * 4 + j / 4;
					case (j % 4)
						0: s = 3;
						1: s = 5;
						2: s = 9;
						default: s = 13;
					endcase
				end
				default: begin
					f = x ^ y ^ z;
					k = K_R3;
					// bit-reversed word order
					idx = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
					case (j % 4)
						0: s = 3;
						1: s = 9;
						2: s = 11;
						default: s = 15;
					endcase
				end
			endcase
			sum = w[t] + f + msg_buf[idx] + k;
			w[t] = (sum << s) | (sum >> (32 - s));
		end
		for (int q = 0; q < 4; q++)
			chain_val[q] = chain_val[q] + w[q];
	endtask

	always @(posedge clk or negedge arst_n) begin
		chain_out_t due;
		logic       emit;
		if (!arst_n) begin
			chain_val[0] = IV_A;
			chain_val[1] = IV_B;
			chain_val[2] = IV_C;
			chain_val[3] = IV_D;
			fill_pos = '0;
			chain_words_due.delete();
			mismatches      <= 0;
			words_owed      <= 0;
			words_taken     <= 0;
			blocks_done     <= 0;
			digests_checked <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				words_taken <= words_taken + 1;
				if (s_tuser) begin
					chain_val[0] = IV_A;
					chain_val[1] = IV_B;
					chain_val[2] = IV_C;
					chain_val[3] = IV_D;
					fill_pos = '0;
				end
				msg_buf[fill_pos] = s_tdata;
				emit = (fill_pos == 4'd15) && s_tlast;
				if (fill_pos == 4'd15) begin
					fold_block();
					blocks_done <= blocks_done + 1;
				end
				fill_pos = fill_pos + 1'b1;
				if (emit) begin
					for (int q = 0; q < 4; q++) begin
						due.chain = chain_val[q];
						due.last  = (q == 3);
						chain_words_due.push_back(due);
					end
				end
			end
			if (m_tvalid && m_tready) begin
				if (chain_words_due.size() == 0) begin
					mismatches <= mismatches + 1;
					$display("%t: unexpected chain word: expected none, got %h last %b",
						$time, m_tdata, m_tlast);
				end else begin
					due = chain_words_due.pop_front();
					digests_checked <= digests_checked + 1;
					if (m_tdata !== due.chain || m_tlast !== due.last) begin
						mismatches <= mismatches + 1;
						$display("%t: chain word mismatch: expected %h last %b, got %h last %b",
							$time, due.chain, due.last, m_tdata, m_tlast);
					end
				end
			end
			words_owed <= chain_words_due.size();
		end
	end

endmodule

// ===== test/md4_block_compression_top_tb.sv =====
// Testbench top for md4_block_compression_top: drives message words, stalls the
// output side and gives the verdict. Depends on md4bc_pkg, the core RTL and
// md4_chain_checker.
module md4_block_compression_top_tb;
	import md4bc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Bound on the slowest legal run, with a wide margin.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 450;
	localparam int QUIET_FROM = 380;   // no idling past this many random words
	// Sized to cover the back end finishing a block plus four output words.
	localparam int DRAIN_CYCLES = 80;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [WORD_W-1:0] s_tdata;    // [31:0] message_word
	logic              s_tuser;    // [0] restart
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [WORD_W-1:0] m_tdata;    // [31:0] chain_word
	logic              m_tlast;

	int mismatches, words_owed, words_taken, blocks_done, digests_checked;
	int cycle_count = 0;
	bit src_gaps;      // source may pause between words
	bit sink_stalls;   // sink may hold off m_tready

	md4_block_compression_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	md4_chain_checker digest_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.mismatches      (mismatches),
		.words_owed      (words_owed),
		.words_taken     (words_taken),
		.blocks_done     (blocks_done),
		.digests_checked (digests_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Guard against a hung handshake: give up well past the slowest good run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Sink side: hold m_tready low for random bursts while stalls are enabled,
	// otherwise keep it high so results drain at full rate.
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Mostly random words, with the all-zeros and all-ones patterns mixed in.
	function automatic logic [WORD_W-1:0] pick_msg_word();
		case ($urandom_range(0, 9))
			0: pick_msg_word = '0;
			1: pick_msg_word = '1;
			default: pick_msg_word = $urandom;
		endcase
	endfunction

	// Present one word and hold it until the core takes it. An optional gap
	// of idle cycles goes in front; valid is only lowered for a real gap, so
	// back-to-back words never see valid dropped and raised in one step.
	task automatic push_msg_word(input logic [WORD_W-1:0] word, input logic rs,
		input logic ends);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= rs;
		s_tlast  <= ends;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	initial begin
		int  sent;
		int  n;
		bit  need_restart;
		bit  first_rs;
		bit  emit;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		s_tlast     = 1'b0;
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a short all-ones stub with an early end flag that must be
		// ignored, then a restart in mid-block that drops the stub.
		push_msg_word('1, 1'b1, 1'b0);
		push_msg_word('1, 1'b0, 1'b1);
		push_msg_word('1, 1'b0, 1'b0);
		push_msg_word('1, 1'b0, 1'b0);
		// Full block of alternating extremes without the end flag: compress
		// silently, wrap the index and carry the chaining value on.
		for (int i = 0; i < 16; i++)
			push_msg_word((i % 2) ? '1 : '0, i == 0, 1'b0);

		// Random: mostly well-formed blocks with random content and flags at
		// their proper places; now and then a stray run of noise words.
		sent = 0;
		need_restart = 1'b0;
		while (sent < RANDOM_WORDS) begin
			src_gaps    = (sent < QUIET_FROM) && ($urandom_range(0, 2) != 0);
			sink_stalls = (sent < QUIET_FROM) && ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 15);
				for (int i = 0; i < n; i++)
					push_msg_word(pick_msg_word(), $urandom_range(0, 5) == 0,
						$urandom_range(0, 3) == 0);
				sent = sent + n;
				need_restart = 1'b1;
			end else begin
				first_rs = need_restart || ($urandom_range(0, 1) == 1);
				emit     = $urandom_range(0, 9) < 7;
				for (int i = 0; i < 16; i++)
					push_msg_word(pick_msg_word(), (i == 0) && first_rs,
						(i == 15) && emit);
				sent = sent + 16;
				need_restart = 1'b0;
			end
		end
		s_tvalid <= 1'b0;

		// Drain: let the owed count catch up with the last word, wait for every
		// owed chain word, then watch a while for strays.
		@(posedge clk);
		while (words_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Fed %0d message words, %0d blocks compressed,", words_taken, blocks_done);
		$display("%0d chain words compared with restarts, early ends and stalls", digests_checked);
		if (mismatches == 0 && words_owed == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
